// ===== hdl/acr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the arc-consistency revise unit.
// Depends on nothing; every other file in hdl refers to it by scoped names.
package acr_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_ROW    = 2'd0,
    CMD_LOAD_DOMAIN = 2'd1,
    CMD_REVISE      = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_LOADED   = 2'd0,
    STATUS_UNPRUNED = 2'd1,
    STATUS_PRUNED   = 2'd2,
    STATUS_FAILURE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Result of one revise, handed from the sequencer to the top level.
  typedef struct packed {
    logic             done;
    logic             which;
    status_e          status;
    logic [DataW-1:0] domain;
  } acr_result_t;

endpackage

// ===== hdl/acr_support_mem.sv =====
`timescale 1ns / 1ps
// Support row memory for both directions, one write and one read port.
// Rows never written read as zero through per-entry valid bits. Uses acr_pkg.
module acr_support_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [AddrW-1:0]         wr_addr_i,
  input  logic [acr_pkg::DataW-1:0] wr_data_i,
  input  logic                     rd_en_i,
  input  logic [AddrW-1:0]         rd_addr_i,
  output logic [acr_pkg::DataW-1:0] rd_data_o
);

  logic [acr_pkg::DataW-1:0] mem [Depth];
  logic [Depth-1:0]          valid_q;
  logic [acr_pkg::DataW-1:0] rd_data_q;
  logic                      rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== hdl/acr_revise_seq.sv =====
`timescale 1ns / 1ps
// Revise sequencer: reads one support row per cycle and tests it against the
// other domain with a single AND-then-OR-reduce test. Uses acr_pkg.
module acr_revise_seq #(
  parameter int unsigned NumVals = 32,
  parameter int unsigned IdxW    = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      which_i,
  input  logic [acr_pkg::DataW-1:0] dom_i,
  input  logic [acr_pkg::DataW-1:0] other_i,
  output logic                      busy_o,
  output logic                      rd_en_o,
  output logic [IdxW:0]             rd_addr_o,
  input  logic [acr_pkg::DataW-1:0] rd_data_i,
  output acr_pkg::acr_result_t      result_o
);

  acr_pkg::state_e state_q, state_d;

  logic                      which_q;
  logic [acr_pkg::DataW-1:0] dom_q, other_q, kept_q, kept_d;
  logic [IdxW-1:0]           x_q, rx_q;
  logic                      rvalid_q;
  logic                      supported;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acr_pkg::ST_IDLE:  if (start_i) state_d = acr_pkg::ST_SCAN;
      acr_pkg::ST_SCAN:  if (x_q == IdxW'(NumVals - 1)) state_d = acr_pkg::ST_DRAIN;
      acr_pkg::ST_DRAIN: state_d = acr_pkg::ST_DONE;
      acr_pkg::ST_DONE:  state_d = acr_pkg::ST_IDLE;
      default:           state_d = acr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o  = (state_q != acr_pkg::ST_IDLE);
    rd_en_o = (state_q == acr_pkg::ST_SCAN);
  end

  assign rd_addr_o = {which_q, x_q};

  // The row read last cycle is for value rx_q; keep the value if it is in
  // the domain and some supporting value is still in the other domain.
  assign supported = dom_q[rx_q] & (|(rd_data_i & other_q));

  always_comb begin
    kept_d = kept_q;
    if (rvalid_q && supported) begin
      kept_d = kept_q | (acr_pkg::DataW'(1) << rx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= acr_pkg::ST_IDLE;
      rvalid_q <= 1'b0;
      x_q      <= '0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= (state_q == acr_pkg::ST_SCAN);
      if (state_q == acr_pkg::ST_IDLE) begin
        x_q <= '0;
      end else if (state_q == acr_pkg::ST_SCAN) begin
        x_q <= x_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q <= x_q;
    if (state_q == acr_pkg::ST_IDLE && start_i) begin
      which_q <= which_i;
      dom_q   <= dom_i;
      other_q <= other_i;
      kept_q  <= '0;
    end else begin
      kept_q <= kept_d;
    end
  end

  always_comb begin
    result_o.done   = (state_q == acr_pkg::ST_DONE);
    result_o.which  = which_q;
    result_o.domain = dom_q;
    if (kept_q == dom_q) begin
      result_o.status = acr_pkg::STATUS_UNPRUNED;
    end else if (kept_q == '0) begin
      result_o.status = acr_pkg::STATUS_FAILURE;
    end else begin
      result_o.status = acr_pkg::STATUS_PRUNED;
      result_o.domain = kept_q;
    end
  end

  a_done_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.done |-> $past(state_q == acr_pkg::ST_DRAIN))
    else $error("revise result without a finished scan");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("sequencer not busy after a revise was started");

  a_kept_in_domain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == acr_pkg::ST_DONE) |-> ((kept_q & ~dom_q) == '0))
    else $error("kept values outside the revised domain");

endmodule

// ===== hdl/binary_arc_consistency_revise_unit.sv =====
`timescale 1ns / 1ps
// Top level of the arc-consistency revise unit: command decode, domain
// registers and result register. Uses acr_pkg, acr_support_mem, acr_revise_seq.

// Load commands (support row, domain, unused code) are taken while busy_o is low and
// their result strobes done_o in the next cycle; busy_o stays low, so such
// commands may be issued back to back. A revise reads one support row per
// cycle from the single read port of the support memory, keeps busy_o high
// through its scan, drain and done states, and strobes its result in the cycle
// in which busy_o has fallen, when the next transaction may already be taken.
// Every result is on status_o and domain_bits_o for exactly one cycle while
// done_o is high and cannot be held off. Support rows read as zero until
// loaded through per-row valid bits, so there is no clearing pass after reset.
module binary_arc_consistency_revise_unit #(
  parameter int unsigned DOMAIN_SIZE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic        which_variable_i,
  input  logic [4:0]  value_index_i,
  input  logic [31:0] value_bits_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] domain_bits_o
);

  localparam int unsigned NumVals = (DOMAIN_SIZE < 32) ? DOMAIN_SIZE : 32;
  localparam int unsigned IdxW    = $clog2(NumVals);
  localparam logic [31:0] ValMask = {32{1'b1}} >> (32 - NumVals);

  acr_pkg::cmd_e        cmd;
  acr_pkg::acr_result_t result;

  logic        accept, row_we, rev_start, in_range, rd_en;
  logic [IdxW:0] rd_addr;
  logic [31:0] bits_m, rd_data, sel_dom, oth_dom;
  logic [31:0] dom_first_q, dom_first_d, dom_second_q, dom_second_d;
  logic        done_q, done_d;
  logic [1:0]  status_q, status_d;
  logic [31:0] dom_out_q, dom_out_d;

  assign accept    = start_i & ~busy_o;
  assign cmd       = acr_pkg::cmd_e'(command_i);
  assign bits_m    = value_bits_i & ValMask;
  assign in_range  = (32'(value_index_i) < 32'(NumVals));
  assign row_we    = accept && (cmd == acr_pkg::CMD_LOAD_ROW) && in_range;
  assign rev_start = accept && (cmd == acr_pkg::CMD_REVISE);
  assign sel_dom   = which_variable_i ? dom_second_q : dom_first_q;
  assign oth_dom   = which_variable_i ? dom_first_q : dom_second_q;

  // The second table starts at the next power of two, so the memory covers
  // the full address range even when the value count is not a power of two.
  acr_support_mem #(
    .Depth (2 ** (IdxW + 1)),
    .AddrW (IdxW + 1)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (row_we),
    .wr_addr_i ({which_variable_i, value_index_i[IdxW-1:0]}),
    .wr_data_i (bits_m),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  acr_revise_seq #(
    .NumVals (NumVals),
    .IdxW    (IdxW)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rev_start),
    .which_i   (which_variable_i),
    .dom_i     (sel_dom),
    .other_i   (oth_dom),
    .busy_o    (busy_o),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .result_o  (result)
  );

  always_comb begin
    dom_first_d  = dom_first_q;
    dom_second_d = dom_second_q;
    done_d       = 1'b0;
    status_d     = acr_pkg::STATUS_LOADED;
    dom_out_d    = dom_out_q;
    if (result.done) begin
      // A failed or unpruned revise returns the old domain, so writing back
      // the result domain is always correct.
      if (result.which) begin
        dom_second_d = result.domain;
      end else begin
        dom_first_d = result.domain;
      end
      done_d    = 1'b1;
      status_d  = result.status;
      dom_out_d = result.domain;
    end else if (accept && !rev_start) begin
      done_d    = 1'b1;
      dom_out_d = sel_dom;
      if (cmd == acr_pkg::CMD_LOAD_DOMAIN) begin
        dom_out_d = bits_m;
        if (which_variable_i) begin
          dom_second_d = bits_m;
        end else begin
          dom_first_d = bits_m;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_first_q  <= '0;
      dom_second_q <= '0;
      done_q       <= 1'b0;
    end else begin
      dom_first_q  <= dom_first_d;
      dom_second_q <= dom_second_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    dom_out_q <= dom_out_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign domain_bits_o = dom_out_q;

endmodule

// ===== test/binary_arc_consistency_revise_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for binary_arc_consistency_revise_unit: a queue-fed driver,
// a strobe monitor and an in-order predictor of support rows, domains and revises.
// Depends on acr_pkg and the unit's top level only.
module binary_arc_consistency_revise_unit_tb;

  localparam int unsigned DOMAIN_SIZE = 32;
  localparam logic [31:0] ValueMask =
      (DOMAIN_SIZE >= 32) ? 32'hFFFF_FFFF : ((32'h1 << DOMAIN_SIZE) - 32'h1);
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int ItemTarget = 1900;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 2 * DOMAIN_SIZE + 10;
  localparam int MaxReported = 10;

  typedef struct packed {
    logic [1:0]  command;
    logic        which;
    logic [4:0]  index;
    logic [31:0] bits;
  } revise_item_t;

  typedef struct packed {
    acr_pkg::status_e status;
    logic [31:0]      domain;
  } domain_outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  command_i = '0;
  logic        which_variable_i = 1'b0;
  logic [4:0]  value_index_i = '0;
  logic [31:0] value_bits_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] domain_bits_o;

  // Predictor state: both support tables and both domains.
  logic [31:0] rows_first [32];
  logic [31:0] rows_second [32];
  logic [31:0] dom_first;
  logic [31:0] dom_second;

  revise_item_t    pending_items[$];
  domain_outcome_t expected_outcomes[$];
  revise_item_t    active_item;

  int item_total = 0;
  int dispatched = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int status_seen [4];

  binary_arc_consistency_revise_unit #(
    .DOMAIN_SIZE(DOMAIN_SIZE)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .which_variable_i(which_variable_i),
    .value_index_i   (value_index_i),
    .value_bits_i    (value_bits_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .domain_bits_o   (domain_bits_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic domain_outcome_t apply_command(revise_item_t it);
    domain_outcome_t res;
    logic [31:0]     masked;
    logic [31:0]     dom;
    logic [31:0]     other;
    logic [31:0]     kept;
    logic [31:0]     row;
    int unsigned     x;
    masked = it.bits & ValueMask;
    res.status = acr_pkg::STATUS_LOADED;
    case (it.command)
      acr_pkg::CMD_LOAD_ROW: begin
        if (it.index < DOMAIN_SIZE) begin
          if (it.which) rows_second[it.index] = masked;
          else rows_first[it.index] = masked;
        end
      end
      acr_pkg::CMD_LOAD_DOMAIN: begin
        if (it.which) dom_second = masked;
        else dom_first = masked;
      end
      acr_pkg::CMD_REVISE: begin
        dom = it.which ? dom_second : dom_first;
        other = it.which ? dom_first : dom_second;
        kept = '0;
        for (x = 0; x < 32; x++) begin
          row = it.which ? rows_second[x] : rows_first[x];
          if (dom[x] && ((row & other) != '0)) kept[x] = 1'b1;
        end
        // A revise that would empty the domain reports failure and keeps it as it was.
        if (kept == dom) begin
          res.status = acr_pkg::STATUS_UNPRUNED;
        end else if (kept == '0) begin
          res.status = acr_pkg::STATUS_FAILURE;
        end else begin
          res.status = acr_pkg::STATUS_PRUNED;
          if (it.which) dom_second = kept;
          else dom_first = kept;
        end
      end
      default: ;
    endcase
    res.domain = it.which ? dom_second : dom_first;
    return res;
  endfunction

  function automatic int sender_idle_pct();
    if (dispatched < item_total / 3) return 15;
    if (dispatched < (2 * item_total) / 3) return 80;
    return 0;
  endfunction

  // Mixes sparse, dense, single-bit, single-hole, full and empty masks so revises hit every outcome.
  function automatic logic [31:0] random_mask();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom & $urandom & $urandom;
      2: return $urandom | $urandom;
      3: return 32'h1 << $urandom_range(31);
      4: return ~(32'h1 << $urandom_range(31));
      default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  task automatic queue_item(logic [1:0] command, logic which, logic [4:0] index,
                            logic [31:0] bits);
    revise_item_t it;
    it.command = command;
    it.which = which;
    it.index = index;
    it.bits = bits;
    pending_items.push_back(it);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      command_i <= '0;
      which_variable_i <= 1'b0;
      value_index_i <= '0;
      value_bits_i <= '0;
    end else begin
      if (start_i && !busy_o) begin
        expected_outcomes.push_back(apply_command(active_item));
        accepted_count++;
      end
      if (!start_i || !busy_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          active_item = pending_items.pop_front();
          dispatched++;
          start_i <= 1'b1;
          command_i <= active_item.command;
          which_variable_i <= active_item.which;
          value_index_i <= active_item.index;
          value_bits_i <= active_item.bits;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    domain_outcome_t exp_out;
    if (rst_ni && done_o) begin
      if (expected_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display("Result with no pending transaction: status %0d domain %h",
                   status_o, domain_bits_o);
      end else begin
        exp_out = expected_outcomes.pop_front();
        status_seen[exp_out.status]++;
        if (status_o !== exp_out.status || domain_bits_o !== exp_out.domain) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display("Mismatch: expected status %0d domain %h, got status %0d domain %h",
                     exp_out.status, exp_out.domain, status_o, domain_bits_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("binary_arc_consistency_revise_unit_tb failed");
      $finish;
    end
  end

  initial begin
    logic dir;
    for (int i = 0; i < 32; i++) begin
      rows_first[i] = '0;
      rows_second[i] = '0;
    end
    dom_first = '0;
    dom_second = '0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;

    // Directed part: empty domain, never-loaded rows, extremes, unused code.
    queue_item(acr_pkg::CMD_REVISE, 1'b0, 5'd31, 32'hFFFF_FFFF);
    queue_item(acr_pkg::CMD_REVISE, 1'b1, 5'd0, 32'h0);
    queue_item(acr_pkg::CMD_LOAD_DOMAIN, 1'b0, 5'd0, 32'hFFFF_FFFF);
    queue_item(acr_pkg::CMD_LOAD_DOMAIN, 1'b1, 5'd31, 32'h0000_0001);
    queue_item(acr_pkg::CMD_REVISE, 1'b0, 5'd0, 32'h0);
    queue_item(acr_pkg::CMD_LOAD_ROW, 1'b0, 5'd0, 32'hFFFF_FFFF);
    queue_item(acr_pkg::CMD_LOAD_ROW, 1'b0, 5'd31, 32'h0000_0001);
    queue_item(acr_pkg::CMD_LOAD_ROW, 1'b0, 5'd5, 32'h8000_0000);
    queue_item(acr_pkg::CMD_REVISE, 1'b0, 5'd0, 32'h0);
    queue_item(acr_pkg::CMD_REVISE, 1'b0, 5'd0, 32'h0);
    queue_item(acr_pkg::CMD_LOAD_ROW, 1'b1, 5'd0, 32'h8000_0001);
    queue_item(acr_pkg::CMD_LOAD_ROW, 1'b1, 5'd31, 32'h0);
    queue_item(acr_pkg::CMD_LOAD_DOMAIN, 1'b1, 5'd0, 32'hFFFF_FFFF);
    queue_item(acr_pkg::CMD_REVISE, 1'b1, 5'd31, 32'hFFFF_FFFF);
    queue_item(acr_pkg::CMD_REVISE, 1'b1, 5'd31, 32'hFFFF_FFFF);
    queue_item(CmdUnused, 1'b0, 5'd31, 32'hFFFF_FFFF);
    queue_item(CmdUnused, 1'b1, 5'd0, 32'h0);
    queue_item(acr_pkg::CMD_LOAD_DOMAIN, 1'b1, 5'd0, 32'h0);
    queue_item(acr_pkg::CMD_REVISE, 1'b0, 5'd0, 32'h0);
    queue_item(acr_pkg::CMD_LOAD_ROW, 1'b0, 5'd0, 32'h0);
    queue_item(acr_pkg::CMD_LOAD_DOMAIN, 1'b1, 5'd0, 32'hFFFF_FFFF);
    queue_item(acr_pkg::CMD_REVISE, 1'b0, 5'd0, 32'h0);

    // Random part: mostly load-rows, load-domains, revise sequences, plus noise.
    while (pending_items.size() < ItemTarget) begin
      if ($urandom_range(99) < 20) begin
        queue_item(2'($urandom_range(3)), 1'($urandom_range(1)), 5'($urandom_range(31)),
                   random_mask());
      end else begin
        dir = 1'($urandom_range(1));
        repeat ($urandom_range(1, 8))
          queue_item(acr_pkg::CMD_LOAD_ROW, dir, 5'($urandom_range(31)), random_mask());
        if ($urandom_range(2) == 0)
          repeat ($urandom_range(1, 4))
            queue_item(acr_pkg::CMD_LOAD_ROW, ~dir, 5'($urandom_range(31)), random_mask());
        if ($urandom_range(1))
          queue_item(acr_pkg::CMD_LOAD_DOMAIN, 1'b0, 5'($urandom_range(31)), random_mask());
        if ($urandom_range(1))
          queue_item(acr_pkg::CMD_LOAD_DOMAIN, 1'b1, 5'($urandom_range(31)), random_mask());
        repeat ($urandom_range(1, 3))
          queue_item(acr_pkg::CMD_REVISE, $urandom_range(3) == 0 ? ~dir : dir,
                     5'($urandom_range(31)), $urandom);
      end
    end
    item_total = pending_items.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_count < item_total) @(posedge clk_i);
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Applied %0d transactions under three sender idling profiles in %0d cycles.",
             accepted_count, cycle_count);
    $display("Results by status: %0d loaded, %0d unpruned, %0d pruned, %0d failure.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
      $display("binary_arc_consistency_revise_unit_tb passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("binary_arc_consistency_revise_unit_tb failed");
    end
    $finish;
  end

endmodule
